FILE: rtl/kt_pkg.sv
// kt_pkg: shared types and token codes for the keyword tokenizer.
// No dependencies; used by every module under rtl/.
`default_nettype none
package kt_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_NUMBER  = 3'd2,
        MODE_COMMENT = 3'd3,
        MODE_RELOP   = 3'd4,
        MODE_EQUAL   = 3'd5
    } t_mode;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [3:0] token_kind;
        logic [7:0] token_char;
        logic       last_of_run;
    } t_out;

    typedef struct packed {
        t_mode      mode;
        logic [9:0] cand;
        logic [2:0] cnt;
        logic       only_dot;
        logic [7:0] op_char;
    } t_lex_state;

    localparam int NUM_KW = 10;

    localparam logic [3:0] TK_EOF      = 4'd0;
    localparam logic [3:0] TK_IDENT    = 4'd3;
    localparam logic [3:0] TK_NUMBER   = 4'd4;
    localparam logic [3:0] TK_PROPERTY = 4'd11;
    localparam logic [3:0] TK_ARITH    = 4'd12;
    localparam logic [3:0] TK_LOGIC    = 4'd13;
    localparam logic [3:0] TK_ASSIGN   = 4'd14;
    localparam logic [3:0] TK_CHAR     = 4'd15;

endpackage
`default_nettype wire

FILE: rtl/kt_step.sv
// kt_step: combinational next-state and token logic for one source byte.
// Depends on kt_pkg (state, payload and token codes).
`default_nettype none
module kt_step (
    input  wire kt_pkg::t_lex_state i_st,
    input  wire kt_pkg::t_in        i_in,
    output kt_pkg::t_lex_state      o_st,
    output logic [1:0]              o_num,
    output kt_pkg::t_out            o_r0,
    output kt_pkg::t_out            o_r1
);

    function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
        logic [63:0] s;
        case (k)
            0:       s = {"def", 40'h0};
            1:       s = {"extern", 16'h0};
            2:       s = {"int", 40'h0};
            3:       s = {"float", 24'h0};
            4:       s = {"double", 16'h0};
            5:       s = {"#arg", 32'h0};
            6:       s = {"main", 32'h0};
            7:       s = {"for", 40'h0};
            8:       s = {"in", 48'h0};
            9:       s = {"return", 16'h0};
            default: s = 64'h0;
        endcase
        return s[8*(7-int'(pos)) +: 8];
    endfunction

    function automatic logic [2:0] kw_len(input int k);
        case (k)
            0, 2, 7:    return 3'd3;
            1, 4, 9:    return 3'd6;
            3:          return 3'd5;
            5, 6:       return 3'd4;
            8:          return 3'd2;
            default:    return 3'd0;
        endcase
    endfunction

    function automatic logic [3:0] kw_kind(input int k);
        case (k)
            0:          return 4'd1;
            1:          return 4'd2;
            2, 3, 4:    return 4'd5;
            5:          return 4'd6;
            6:          return 4'd7;
            7:          return 4'd8;
            8:          return 4'd9;
            9:          return 4'd10;
            default:    return kt_pkg::TK_IDENT;
        endcase
    endfunction

    logic [7:0] c;
    logic       is_alpha, is_digit, is_space, is_nl;

    // keyword match from the current candidates, and from a fresh identifier
    logic [9:0] m_cand, s_cand;
    logic [2:0] m_cnt;
    logic [3:0] id_kind;

    logic                flush_v;
    kt_pkg::t_out        flush_tok;
    logic                start_v;
    kt_pkg::t_out        start_tok;
    kt_pkg::t_lex_state  start_st;

    logic                pre_v, do_start;
    kt_pkg::t_out        pre_tok;
    kt_pkg::t_lex_state  base_st;

    assign c        = i_in.text_byte;
    assign is_alpha = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    assign is_digit = (c >= 8'h30 && c <= 8'h39);
    assign is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
    assign is_nl    = (c == 8'h0a) || (c == 8'h0d);

    always_comb begin
        for (int k = 0; k < kt_pkg::NUM_KW; k++) begin
            m_cand[k] = i_st.cand[k] && (i_st.cnt < kw_len(k)) && (kw_char(k, i_st.cnt) == c);
            s_cand[k] = (kw_len(k) != 3'd0) && (kw_char(k, 3'd0) == c);
        end
        if (i_st.cnt == 3'd7) begin
            m_cand = '0;
            m_cnt  = 3'd7;
        end else begin
            m_cnt  = i_st.cnt + 3'd1;
        end
    end

    always_comb begin
        id_kind = kt_pkg::TK_IDENT;
        for (int k = kt_pkg::NUM_KW - 1; k >= 0; k--) begin
            if (i_st.cand[k] && i_st.cnt == kw_len(k)) begin
                id_kind = kw_kind(k);
            end
        end
    end

    // token that the pending state gives when it is cut off
    always_comb begin
        flush_v   = 1'b1;
        flush_tok = '0;
        case (i_st.mode)
            kt_pkg::MODE_IDENT:  flush_tok.token_kind = id_kind;
            kt_pkg::MODE_NUMBER: flush_tok.token_kind = i_st.only_dot ?
                                     kt_pkg::TK_PROPERTY : kt_pkg::TK_NUMBER;
            kt_pkg::MODE_RELOP: begin
                flush_tok.token_kind = kt_pkg::TK_LOGIC;
                flush_tok.token_char = i_st.op_char;
            end
            kt_pkg::MODE_EQUAL: begin
                flush_tok.token_kind = kt_pkg::TK_ASSIGN;
                flush_tok.token_char = 8'h3d;
            end
            default: flush_v = 1'b0;
        endcase
    end

    // byte scanned as the first of a new token
    always_comb begin
        start_v        = 1'b0;
        start_tok      = '0;
        start_st       = i_st;
        start_st.mode  = kt_pkg::MODE_IDLE;
        if (is_space) begin
            start_st.mode = kt_pkg::MODE_IDLE;
        end else if (is_alpha || c == 8'h23) begin
            start_st.mode = kt_pkg::MODE_IDENT;
            start_st.cand = s_cand;
            start_st.cnt  = 3'd1;
        end else if (is_digit || c == 8'h2e) begin
            start_st.mode     = kt_pkg::MODE_NUMBER;
            start_st.only_dot = (c == 8'h2e);
        end else if (c == 8'h24) begin
            start_st.mode = kt_pkg::MODE_COMMENT;
        end else if (c == 8'h2b || c == 8'h2d || c == 8'h2a || c == 8'h2f) begin
            start_v              = 1'b1;
            start_tok.token_kind = kt_pkg::TK_ARITH;
            start_tok.token_char = c;
        end else if (c == 8'h3c || c == 8'h3e || c == 8'h7e) begin
            start_st.mode    = kt_pkg::MODE_RELOP;
            start_st.op_char = c;
        end else if (c == 8'h3d) begin
            start_st.mode = kt_pkg::MODE_EQUAL;
        end else begin
            start_v              = 1'b1;
            start_tok.token_kind = kt_pkg::TK_CHAR;
            start_tok.token_char = c;
        end
    end

    always_comb begin
        pre_v         = 1'b0;
        pre_tok       = flush_tok;
        do_start      = 1'b0;
        base_st       = i_st;
        base_st.mode  = kt_pkg::MODE_IDLE;
        if (i_in.end_of_text || c == 8'h00) begin
            pre_v = flush_v;
        end else begin
            case (i_st.mode)
                kt_pkg::MODE_IDENT: begin
                    if (is_alpha || is_digit || c == 8'h5f) begin
                        base_st.mode = kt_pkg::MODE_IDENT;
                        base_st.cand = m_cand;
                        base_st.cnt  = m_cnt;
                    end else begin
                        pre_v    = 1'b1;
                        do_start = 1'b1;
                    end
                end
                kt_pkg::MODE_NUMBER: begin
                    if (is_digit || c == 8'h2e) begin
                        base_st.mode     = kt_pkg::MODE_NUMBER;
                        base_st.only_dot = 1'b0;
                    end else begin
                        pre_v    = 1'b1;
                        do_start = 1'b1;
                    end
                end
                kt_pkg::MODE_COMMENT: begin
                    if (!is_nl) begin
                        base_st.mode = kt_pkg::MODE_COMMENT;
                    end
                end
                kt_pkg::MODE_RELOP: begin
                    pre_v    = 1'b1;
                    do_start = (c != 8'h3d);
                end
                kt_pkg::MODE_EQUAL: begin
                    pre_v = 1'b1;
                    if (c == 8'h3d) begin
                        pre_tok.token_kind = kt_pkg::TK_LOGIC;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                default: do_start = 1'b1;
            endcase
        end
    end

    // pack the results in order; the final one carries the last flag
    always_comb begin
        kt_pkg::t_out second;
        logic         second_v;
        second   = start_tok;
        second_v = do_start && start_v;
        if (i_in.end_of_text || c == 8'h00) begin
            second   = '0;
            second.token_kind = kt_pkg::TK_EOF;
            second_v = 1'b1;
        end
        o_st  = do_start ? start_st : base_st;
        o_r0  = pre_v ? pre_tok : second;
        o_r1  = second;
        o_r0.last_of_run = !(pre_v && second_v);
        o_r1.last_of_run = 1'b1;
        o_num = 2'(pre_v) + 2'(second_v);
    end

endmodule
`default_nettype wire

FILE: rtl/kt_fifo.sv
// kt_fifo: result queue that takes up to two tokens a cycle and hands out one when not stalled.
// Depends on kt_pkg (result payload type).
`default_nettype none
module kt_fifo #(
    parameter int DEPTH = 4
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push0,
    input  wire                i_push1,
    input  wire kt_pkg::t_out  i_d0,
    input  wire kt_pkg::t_out  i_d1,
    output logic               o_room2,
    output logic               o_valid,
    input  wire                i_stall,
    output kt_pkg::t_out       o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
        return (p == LAST) ? '0 : p + PW'(1);
    endfunction

    kt_pkg::t_out  r_mem [DEPTH];
    logic [PW-1:0] r_rd, r_wr, n_rd, n_wr, wr1;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign o_room2 = (r_cnt <= CW'(DEPTH - 2));
    assign pop     = o_valid && !i_stall;
    assign wr1     = inc(r_wr);

    always_comb begin
        n_rd  = pop ? inc(r_rd) : r_rd;
        n_wr  = r_wr;
        n_cnt = r_cnt - CW'(pop);
        if (i_push0 && i_push1) begin
            n_wr  = inc(wr1);
            n_cnt = n_cnt + CW'(2);
        end else if (i_push0) begin
            n_wr  = wr1;
            n_cnt = n_cnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr] <= i_d0;
        end
        if (i_push0 && i_push1) begin
            r_mem[wr1] <= i_d1;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("result queue count above depth");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push0 && i_push1) |-> o_room2)
        else $error("two results pushed without room");

    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push1 |-> i_push0)
        else $error("second result pushed without first");

endmodule
`default_nettype wire

FILE: rtl/keyword_tokenizer.sv
// keyword_tokenizer: streaming lexer top level, byte in, token classes out.
// Depends on kt_pkg, kt_step and kt_fifo.
//
//  channel | valid       | stall        | payload            | moves
//  --------+-------------+--------------+--------------------+---------------------
//  input   | i_in_valid  | o_in_stall   | i_in  (t_in)       | one byte or end mark
//  output  | o_out_valid | i_out_stall  | o_out (t_out)      | one token
//
// One byte is taken every cycle unless o_in_stall is high. A taken byte is scanned
// from the input register and its 0, 1 or 2 tokens are written into the result
// queue, whose head entry drives o_out without a further register in between.
// The input register holds while the queue has fewer than two free entries, so
// sustained rate is one byte per cycle as long as tokens drain at least as fast.
// Synchronous active-low reset: lexer idle, queue empty, no clearing pass.
`default_nettype none
module keyword_tokenizer #(
    parameter int DEPTH = 4
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire kt_pkg::t_in  i_in,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output kt_pkg::t_out      o_out
);

    logic               r_in_valid, n_in_valid;
    kt_pkg::t_in        r_in;
    kt_pkg::t_lex_state r_st, step_st;
    logic [1:0]         step_num;
    kt_pkg::t_out       step_r0, step_r1;
    logic               room2, proc, take;

    assign proc       = r_in_valid && room2;
    assign o_in_stall = r_in_valid && !room2;
    assign take       = i_in_valid && !o_in_stall;
    assign n_in_valid = take || (r_in_valid && !proc);

    kt_step u_step (
        .i_st  (r_st),
        .i_in  (r_in),
        .o_st  (step_st),
        .o_num (step_num),
        .o_r0  (step_r0),
        .o_r1  (step_r1)
    );

    kt_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (proc && step_num != 2'd0),
        .i_push1 (proc && step_num == 2'd2),
        .i_d0    (step_r0),
        .i_d1    (step_r1),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_st       <= '{mode: kt_pkg::MODE_IDLE, cand: '0, cnt: '0,
                            only_dot: 1'b0, op_char: '0};
        end else begin
            r_in_valid <= n_in_valid;
            if (proc) begin
                r_st <= step_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in <= i_in;
        end
    end

    a_eof_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && (r_in.end_of_text || r_in.text_byte == 8'h00))
        |=> r_st.mode == kt_pkg::MODE_IDLE)
        else $error("lexer not idle after end of text");

    a_eof_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in.end_of_text) |-> step_num != 2'd0)
        else $error("end of text gave no token");

    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !proc) |=> (r_in_valid && $stable(r_in)))
        else $error("held byte lost or changed");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && step_num == 2'd1) |-> step_r0.last_of_run)
        else $error("single token without last flag");

endmodule
`default_nettype wire

FILE: tb/kt_tb_pkg.sv
// kt_tb_pkg: keyword table and token scoreboard for the keyword tokenizer bench.
// Depends on kt_pkg for the transaction structs, scan modes and token kinds.
package kt_tb_pkg;
    import kt_pkg::*;

    localparam logic [3:0] TK_DEF      = 4'd1;
    localparam logic [3:0] TK_EXTERN   = 4'd2;
    localparam logic [3:0] TK_TYPE     = 4'd5;
    localparam logic [3:0] TK_ARGARRAY = 4'd6;
    localparam logic [3:0] TK_MAIN     = 4'd7;
    localparam logic [3:0] TK_FOR      = 4'd8;
    localparam logic [3:0] TK_IN       = 4'd9;
    localparam logic [3:0] TK_RETURN   = 4'd10;

    function automatic string kw_word(int k);
        case (k)
            0: return "def";
            1: return "extern";
            2: return "int";
            3: return "float";
            4: return "double";
            5: return "#arg";
            6: return "main";
            7: return "for";
            8: return "in";
            default: return "return";
        endcase
    endfunction

    function automatic logic [3:0] kw_kind(int k);
        case (k)
            0: return TK_DEF;
            1: return TK_EXTERN;
            2, 3, 4: return TK_TYPE;
            5: return TK_ARGARRAY;
            6: return TK_MAIN;
            7: return TK_FOR;
            8: return TK_IN;
            default: return TK_RETURN;
        endcase
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == " " || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    class token_scoreboard;
        t_mode      mode;
        logic [9:0] cand;
        logic [2:0] cnt;
        logic       only_dot;
        logic [7:0] op_char;
        t_out       expected_tokens[$];
        t_out       step_tokens[$];
        int         failures;

        function new();
            mode     = MODE_IDLE;
            cand     = '0;
            cnt      = '0;
            only_dot = 1'b0;
            op_char  = '0;
            failures = 0;
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        local function void emit(logic [3:0] kind, logic [7:0] ch);
            t_out tok;
            tok.token_kind  = kind;
            tok.token_char  = ch;
            tok.last_of_run = 1'b0;
            step_tokens.insert(step_tokens.size(), tok);
        endfunction

        // narrow the keyword candidates by the byte at the current position
        local function void match_letter(logic [7:0] c);
            logic [9:0] keep;
            keep = '0;
            for (int k = 0; k < NUM_KW; k++) begin
                string w;
                w = kw_word(k);
                if (cand[k] && cnt < w.len() && w[cnt] == c)
                    keep[k] = 1'b1;
            end
            cand = keep;
            if (cnt < 3'd7)
                cnt++;
            else
                cand = '0;
        endfunction

        local function logic [3:0] word_kind();
            for (int k = 0; k < NUM_KW; k++) begin
                string w;
                w = kw_word(k);
                if (cand[k] && cnt == w.len())
                    return kw_kind(k);
            end
            return TK_IDENT;
        endfunction

        local function void flush_token();
            case (mode)
                MODE_IDENT:  emit(word_kind(), 8'h00);
                MODE_NUMBER: emit(only_dot ? TK_PROPERTY : TK_NUMBER, 8'h00);
                MODE_RELOP:  emit(TK_LOGIC, op_char);
                MODE_EQUAL:  emit(TK_ASSIGN, "=");
                default: ;
            endcase
            mode = MODE_IDLE;
        endfunction

        local function void start_token(logic [7:0] c);
            mode = MODE_IDLE;
            if (is_blank(c))
                return;
            if (is_letter(c) || c == "#") begin
                mode = MODE_IDENT;
                cand = '1;
                cnt  = '0;
                match_letter(c);
            end else if (is_digit(c) || c == ".") begin
                mode     = MODE_NUMBER;
                only_dot = (c == ".");
            end else if (c == "$") begin
                mode = MODE_COMMENT;
            end else if (c == "+" || c == "-" || c == "*" || c == "/") begin
                emit(TK_ARITH, c);
            end else if (c == "<" || c == ">" || c == "~") begin
                mode    = MODE_RELOP;
                op_char = c;
            end else if (c == "=") begin
                mode = MODE_EQUAL;
            end else begin
                emit(TK_CHAR, c);
            end
        endfunction

        // one accepted input transaction: advance the lexer, queue its tokens
        function void note_byte(t_in item);
            logic [7:0] c;
            c = item.text_byte;
            step_tokens.delete();
            if (item.end_of_text || c == 8'h00) begin
                flush_token();
                emit(TK_EOF, 8'h00);
            end else begin
                case (mode)
                    MODE_IDENT: begin
                        if (is_letter(c) || is_digit(c) || c == "_") begin
                            match_letter(c);
                        end else begin
                            flush_token();
                            start_token(c);
                        end
                    end
                    MODE_NUMBER: begin
                        if (is_digit(c) || c == ".") begin
                            only_dot = 1'b0;
                        end else begin
                            flush_token();
                            start_token(c);
                        end
                    end
                    MODE_COMMENT: begin
                        if (c == 8'h0a || c == 8'h0d)
                            mode = MODE_IDLE;
                    end
                    MODE_RELOP: begin
                        emit(TK_LOGIC, op_char);
                        mode = MODE_IDLE;
                        if (c != "=")
                            start_token(c);
                    end
                    MODE_EQUAL: begin
                        mode = MODE_IDLE;
                        if (c == "=") begin
                            emit(TK_LOGIC, "=");
                        end else begin
                            emit(TK_ASSIGN, "=");
                            start_token(c);
                        end
                    end
                    default: start_token(c);
                endcase
            end
            for (int i = 0; i < step_tokens.size(); i++) begin
                t_out tok;
                tok = step_tokens[i];
                tok.last_of_run = (i == step_tokens.size() - 1);
                expected_tokens.insert(expected_tokens.size(), tok);
            end
        endfunction

        function void check_token(t_out got);
            t_out want;
            if (expected_tokens.size() == 0) begin
                $error("unpredicted token: token_kind %0d token_char 0x%02h",
                       got.token_kind, got.token_char);
                failures++;
                return;
            end
            want = expected_tokens.pop_front();
            if (got.token_kind !== want.token_kind) begin
                $error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
                failures++;
            end
            if (got.token_char !== want.token_char) begin
                $error("token_char: expected 0x%02h, got 0x%02h",
                       want.token_char, got.token_char);
                failures++;
            end
            if (got.last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %0b, got %0b",
                       want.last_of_run, got.last_of_run);
                failures++;
            end
        endfunction
    endclass

endpackage

FILE: tb/tb_keyword_tokenizer.sv
// tb_keyword_tokenizer: drives byte streams into keyword_tokenizer and checks tokens.
// Depends on kt_pkg and kt_tb_pkg (scoreboard); random gaps and stalls on both sides.
module tb_keyword_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    import kt_pkg::*;
    import kt_tb_pkg::*;

    localparam int TOTAL_ITEMS    = 1625;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 10;

    logic  i_clk;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    logic  i_out_stall = 1'b0;
    t_in   i_in        = '0;
    logic  o_in_stall;
    logic  o_out_valid;
    t_out  o_out;

    token_scoreboard sb = new();
    bit    calm = 1'b0;
    int    sent_items = 0;
    int    quiet_cycles = 0;
    int    stall_left = 0;

    keyword_tokenizer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        if (r < 26) return 8'("a" + r);
        return 8'("A" + r - 26);
    endfunction

    // monitor, scoreboard hookup and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_byte(i_in);
            if (o_out_valid && !i_out_stall)
                sb.check_token(o_out);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // output backpressure
    initial begin
        forever begin
            @(negedge i_clk);
            if (calm)
                stall_left = 0;
            else if (stall_left == 0 && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            i_out_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        t_in item;
        int  gap;
        item.text_byte   = b;
        item.end_of_text = eot;
        gap = calm ? 0 : pick_gap();
        @(negedge i_clk);
        i_in       <= item;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sent_items++;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    // sender holds off until every predicted token has come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    // one random lexeme, mostly well formed, sometimes noise or end of text
    task automatic emit_token();
        logic [7:0] chars[$];
        string      w;
        string      punct;
        int         r;
        int         n;
        int         c;
        punct = "()[]{};,:!?@%^&|`'";
        r = $urandom_range(0, 99);
        if (r < 20) begin
            w = kw_word($urandom_range(0, NUM_KW - 1));
            for (int i = 0; i < w.len(); i++)
                chars.insert(chars.size(), w[i]);
            if ($urandom_range(0, 3) == 0)
                chars.insert(chars.size(),
                             $urandom_range(0, 1) ? rand_letter() : 8'("_"));
            if ($urandom_range(0, 1) == 0)
                chars.insert(chars.size(), " ");
        end else if (r < 35) begin
            chars.insert(chars.size(), $urandom_range(0, 9) == 0 ? 8'("#") : rand_letter());
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            for (int i = 1; i < n; i++) begin
                case ($urandom_range(0, 3))
                    0, 1: chars.insert(chars.size(), rand_letter());
                    2: chars.insert(chars.size(), 8'("0" + $urandom_range(0, 9)));
                    default: chars.insert(chars.size(), "_");
                endcase
            end
        end else if (r < 45) begin
            if ($urandom_range(0, 4) == 0) begin
                chars.insert(chars.size(), ".");
            end else begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    chars.insert(chars.size(),
                                 $urandom_range(0, 3) == 0 ? 8'(".")
                                                           : 8'("0" + $urandom_range(0, 9)));
            end
        end else if (r < 60) begin
            case ($urandom_range(0, 11))
                0: w = "+";
                1: w = "-";
                2: w = "*";
                3: w = "/";
                4: w = "<";
                5: w = "<=";
                6: w = ">";
                7: w = ">=";
                8: w = "~";
                9: w = "~=";
                10: w = "=";
                default: w = "==";
            endcase
            for (int i = 0; i < w.len(); i++)
                chars.insert(chars.size(), w[i]);
        end else if (r < 70) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                chars.insert(chars.size(),
                             $urandom_range(0, 2) != 0 ? 8'(" ") : 8'($urandom_range(9, 13)));
        end else if (r < 78) begin
            chars.insert(chars.size(), "$");
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
                c = $urandom_range(1, 255);
                if (c == 10 || c == 13)
                    c = "x";
                chars.insert(chars.size(), 8'(c));
            end
            // NUL inside a comment now and then
            case ($urandom_range(0, 7))
                0: chars.insert(chars.size(), 8'h00);
                1, 2, 3: chars.insert(chars.size(), 8'h0d);
                default: chars.insert(chars.size(), 8'h0a);
            endcase
        end else if (r < 88) begin
            if ($urandom_range(0, 1))
                chars.insert(chars.size(), 8'($urandom_range(128, 255)));
            else
                chars.insert(chars.size(), punct[$urandom_range(0, punct.len() - 1)]);
        end else if (r < 97) begin
            chars.insert(chars.size(), 8'($urandom_range(0, 255)));
        end else if (r < 99) begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            chars.insert(chars.size(), 8'h00);
        end
        foreach (chars[i])
            send_byte(chars[i], 1'b0);
    endtask

    initial begin
        bit drained_once;
        drained_once = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: keyword, relational and equality forms, lone dot, number,
        // high bytes, NUL inside a comment, end of text while idle and mid-word
        send_text("#arg<=x==. 3.+~");
        send_byte(8'hff, 1'b0);
        send_text("$z");
        send_byte(8'h00, 1'b0);
        send_text("= ");
        send_byte(8'h80, 1'b0);
        send_byte(8'hff, 1'b1);
        send_text("in");
        send_byte(8'h00, 1'b1);

        while (sent_items < TOTAL_ITEMS) begin
            calm = (sent_items >= 500 && sent_items < 700);
            if (!drained_once && sent_items >= 900) begin
                wait_drained();
                drained_once = 1'b1;
            end
            emit_token();
        end
        calm = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            $error("%0d predicted tokens never arrived", sb.pending());
        if (sb.failures == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/kt_pkg.sv
rtl/kt_step.sv
rtl/kt_fifo.sv
rtl/keyword_tokenizer.sv
tb/kt_tb_pkg.sv
tb/tb_keyword_tokenizer.sv
